@@ sv/iirl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared types and constants of the indexed insert/remove list.
// ----------------------------------------------------------------------------
package iirl_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int CMD_W  = 2;
    localparam int POS_W  = 5;
    localparam int HIN_W  = 16;
    localparam int ERR_W  = 2;
    localparam int CNT_W  = 5;
    localparam int CAP_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_TAKE   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_INSERT = 2'd3
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    // broadcast to every cell for one command
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
    } t_cell_ctl;

endpackage

@@ sv/iirl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_cell
// One list slot: holds a handle, shifts from its left or right neighbour.
// ----------------------------------------------------------------------------
module iirl_cell
    import iirl_pkg::*;
#(
    parameter int HW    = HANDLE_BITS_DEF,
    parameter int INDEX = 0
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [HW-1:0] i_handle,
    input  logic [HW-1:0] i_left,
    input  logic [HW-1:0] i_right,
    output logic [HW-1:0] o_val,
    output logic [HW-1:0] o_rd
);

    logic [HW-1:0] r_val;
    logic [HW-1:0] n_val;
    int            pos_i;
    int            cnt_i;

    always_comb begin
        pos_i = int'(i_ctl.pos);
        cnt_i = int'(i_ctl.cnt);
        n_val = r_val;
        if (i_ctl.ins) begin
            if (INDEX == pos_i) begin
                n_val = i_handle;
            end else if (INDEX > pos_i && INDEX <= cnt_i) begin
                n_val = i_left;
            end
        end else if (i_ctl.rem) begin
            if (INDEX >= pos_i && INDEX + 1 < cnt_i) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_rd  = (INDEX == int'(i_ctl.pos)) ? r_val : '0;

endmodule

@@ sv/indexed_insert_remove_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// Ordered list of handles with read, take, delete and insert at a position.
// ----------------------------------------------------------------------------
// channel  direction  fields (low bit up)
// s_axis   in         command[1:0] position[6:2] handle_in[22:7] pad[23]
// m_axis   out        handle_out[15:0] error[17:16] count[22:18] full_res[23]
// cfg      in         capacity[4:0]
//
// one command per cycle: the affected cells shift or load in the accept cycle, the
// read value comes from an or-tree over the cells into the output register.
// a command is taken whenever the output register is empty or being emptied.
// reset clears the count, the output valid and sets capacity to 16; cell
// contents stay undefined until written. cfg is always ready.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list
    import iirl_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // command, position, handle_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // handle_out, error, count, full_res
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data   // capacity
);

    // stored handles never hold more than the input field carries
    localparam int HW   = (HANDLE_BITS < HIN_W) ? HANDLE_BITS : HIN_W;
    localparam int DCAP = (DEPTH > (2**CNT_W) - 1) ? (2**CNT_W) - 1 : DEPTH;

    logic [CAP_W-1:0] r_cap;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_valid;
    logic [HIN_W-1:0] r_hout;
    t_err             r_err;
    logic [CNT_W-1:0] r_ocnt;
    logic             r_full;

    t_cmd             s_cmd;
    logic [POS_W-1:0] s_pos;
    logic [HW-1:0]    s_handle;
    logic             s_acc;
    t_err             s_err;
    logic [CAP_W-1:0] s_effcap;
    t_cell_ctl        s_ctl;
    logic [HW-1:0]    s_hread;

    logic [HW-1:0] w_val [DEPTH];
    logic [HW-1:0] w_rd  [DEPTH];

    assign s_cmd    = t_cmd'(i_s_axis_tdata[1:0]);
    assign s_pos    = i_s_axis_tdata[6:2];
    assign s_handle = i_s_axis_tdata[7 +: HW];

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign s_effcap = (r_cap > CAP_W'(DCAP)) ? CAP_W'(DCAP) : r_cap;

    always_comb begin
        s_err     = ERR_OK;
        s_ctl.ins = 1'b0;
        s_ctl.rem = 1'b0;
        s_ctl.pos = s_pos;
        s_ctl.cnt = r_cnt;
        n_cnt     = r_cnt;
        if (s_cmd == CMD_INSERT) begin
            // a position past the end appends
            if (s_pos > r_cnt) begin
                s_ctl.pos = r_cnt;
            end
            if (r_cnt >= s_effcap) begin
                s_err = ERR_FULL;
            end else begin
                s_ctl.ins = s_acc;
                n_cnt     = r_cnt + CNT_W'(1);
            end
        end else if (s_pos >= r_cnt) begin
            s_err = ERR_RANGE;
        end else if (s_cmd != CMD_READ) begin
            s_ctl.rem = s_acc;
            n_cnt     = r_cnt - CNT_W'(1);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [HW-1:0] w_left;
        logic [HW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end
        iirl_cell #(
            .HW    (HW),
            .INDEX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (s_ctl),
            .i_handle (s_handle),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_val    (w_val[g]),
            .o_rd     (w_rd[g])
        );
    end

    // only the addressed cell drives a non-zero read value
    always_comb begin
        s_hread = '0;
        for (int k = 0; k < DEPTH; k++) begin
            s_hread = s_hread | w_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_W'(16);
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (s_acc) begin
                r_cnt   <= n_cnt;
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_err  <= s_err;
            r_ocnt <= n_cnt;
            r_full <= (n_cnt == s_effcap);
            if (s_err == ERR_OK && (s_cmd == CMD_READ || s_cmd == CMD_TAKE)) begin
                r_hout <= HIN_W'(s_hread);
            end else begin
                r_hout <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {r_full, r_ocnt, r_err, r_hout};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DCAP))
        else $error("entry count above depth");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_cmd == CMD_INSERT && s_err == ERR_OK)
        |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_err != ERR_OK) |=> (r_cnt == $past(r_cnt)))
        else $error("failed command changed the count");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_err != ERR_OK) |-> (r_hout == '0))
        else $error("error result carries a handle");
`endif

endmodule

@@ tb/indexed_insert_remove_list_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_test
// Self-checking bench for the indexed insert/remove list. Commands go in as
// beats on the slave stream with random gaps, results are taken off the
// master stream under random back-pressure, and every result beat is checked
// field by field against a local model of the list held in this bench.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_test;
    import iirl_pkg::*;

    localparam int RUN_LIMIT = 400000;

    typedef struct packed {
        logic             full_res;
        logic [CNT_W-1:0] count;
        t_err             error;
        logic [HIN_W-1:0] handle_out;
    } t_list_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [23:0]       i_s_axis_tdata = '0;    // command, position, handle_in, pad
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [23:0]       o_m_axis_tdata;         // handle_out, error, count, full_res
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CAP_W-1:0]  i_cfg_data = '0;        // capacity

    // local copy of the list
    logic [HIN_W-1:0]  list_entries [DEPTH_DEF];
    logic [CNT_W-1:0]  list_count = '0;
    logic [CAP_W-1:0]  list_capacity = CAP_W'(16);

    t_list_result      expected_results [$];
    int                mismatch_cnt = 0;
    int                cycle_cnt = 0;
    int                ready_hold = 0;
    bit                no_idle = 1'b0;

    indexed_insert_remove_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 96) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    function automatic int effective_capacity();
        return (list_capacity > DEPTH_DEF) ? DEPTH_DEF : int'(list_capacity);
    endfunction

    // applies one command to the local list and returns the result it gives
    function automatic t_list_result apply_command(input t_cmd cmd,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [HIN_W-1:0] handle);
        t_list_result res;
        int           eff;
        int           p;
        int           i;
        eff = effective_capacity();
        res = '0;
        res.error = ERR_OK;
        if (cmd == CMD_INSERT) begin
            if (list_count >= eff) begin
                res.error = ERR_FULL;
            end else begin
                p = (pos > list_count) ? int'(list_count) : int'(pos);
                for (i = int'(list_count); i > p; i--)
                    list_entries[i] = list_entries[i-1];
                list_entries[p] = handle;
                list_count = list_count + 1'b1;
            end
        end else if (pos >= list_count) begin
            res.error = ERR_RANGE;
        end else begin
            if (cmd != CMD_DELETE)
                res.handle_out = list_entries[pos];
            if (cmd != CMD_READ) begin
                for (i = int'(pos); i + 1 < int'(list_count); i++)
                    list_entries[i] = list_entries[i+1];
                list_count = list_count - 1'b1;
            end
        end
        res.count    = list_count;
        res.full_res = (int'(list_count) == eff);
        return res;
    endfunction

    // receiver: ready runs and stalls of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            ready_hold      <= 0;
        end else if (no_idle) begin
            i_m_axis_tready <= 1'b1;
            ready_hold      <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (i_m_axis_tready && $urandom_range(0, 2) == 0) begin
            i_m_axis_tready <= 1'b0;
            ready_hold      <= idle_len();
        end else begin
            i_m_axis_tready <= 1'b1;
            ready_hold      <= $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_list_result got;
        t_list_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_list_result'(o_m_axis_tdata);
            if (expected_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("result beat %h with nothing outstanding", o_m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got.handle_out !== want.handle_out || got.error !== want.error ||
                    got.count !== want.count || got.full_res !== want.full_res) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result mismatch: expected handle %h error %0d count %0d ",
                                  "full %b, got handle %h error %0d count %0d full %b"},
                                 want.handle_out, want.error, want.count, want.full_res,
                                 got.handle_out, got.error, got.count, got.full_res);
                end
            end
        end
    end

    // called at a rising edge; returns at the edge the beat is taken
    task automatic send_command(input t_cmd cmd, input logic [POS_W-1:0] pos,
                                input logic [HIN_W-1:0] handle);
        int           gap;
        t_list_result res;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, handle, pos, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        res = apply_command(cmd, pos, handle);
        expected_results.insert(expected_results.size(), res);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        list_capacity = value;
        i_cfg_valid <= 1'b0;
    endtask

    // errors on the empty list, appends, inserts at the front and middle
    task automatic test_empty_list();
        send_command(CMD_READ, 5'd0, 16'h1111);
        send_command(CMD_TAKE, 5'd0, 16'h2222);
        send_command(CMD_DELETE, 5'd31, 16'h3333);
        send_command(CMD_INSERT, 5'd31, 16'hffff);
        send_command(CMD_INSERT, 5'd0, 16'h0000);
        send_command(CMD_INSERT, 5'd1, 16'ha5a5);
        send_command(CMD_READ, 5'd0, 16'h0000);
        send_command(CMD_READ, 5'd1, 16'h0000);
        send_command(CMD_READ, 5'd2, 16'h0000);
        send_command(CMD_READ, 5'd3, 16'h0000);
        send_command(CMD_TAKE, 5'd1, 16'h0000);
        send_command(CMD_DELETE, 5'd0, 16'h0000);
        send_command(CMD_TAKE, 5'd0, 16'h5a5a);
    endtask

    // refused inserts when full, capacity lowered under the count, capacity zero
    task automatic test_capacity_limits();
        write_capacity(5'd2);
        send_command(CMD_INSERT, 5'd0, 16'h1234);
        send_command(CMD_INSERT, 5'd5, 16'h5678);
        send_command(CMD_INSERT, 5'd0, 16'h9999);
        write_capacity(5'd1);
        send_command(CMD_INSERT, 5'd0, 16'h7777);
        send_command(CMD_DELETE, 5'd1, 16'h0000);
        write_capacity(5'd0);
        send_command(CMD_TAKE, 5'd0, 16'h0000);
        send_command(CMD_INSERT, 5'd0, 16'hcafe);
    endtask

    // fill and drain trends with mostly legal positions and random handles
    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int n_items,
                                    input bit steady);
        int               k;
        int               pick;
        bit               filling;
        t_cmd             cmd;
        logic [POS_W-1:0] pos;
        write_capacity(cap);
        no_idle = steady;
        filling = 1'b1;
        for (k = 0; k < n_items; k++) begin
            if (list_count >= effective_capacity()) filling = 1'b0;
            else if (list_count == 0) filling = 1'b1;
            else if ($urandom_range(0, 19) == 0) filling = !filling;
            pick = $urandom_range(0, 99);
            if (filling)
                cmd = (pick < 55) ? CMD_INSERT : (pick < 75) ? CMD_READ :
                      (pick < 88) ? CMD_TAKE : CMD_DELETE;
            else
                cmd = (pick < 20) ? CMD_INSERT : (pick < 40) ? CMD_READ :
                      (pick < 70) ? CMD_TAKE : CMD_DELETE;
            if ($urandom_range(0, 9) == 0)
                pos = POS_W'($urandom_range(0, 31));
            else if (cmd == CMD_INSERT)
                pos = POS_W'($urandom_range(0, list_count));
            else if (list_count != 0)
                pos = POS_W'($urandom_range(0, list_count - 1));
            else
                pos = POS_W'($urandom_range(0, 31));
            send_command(cmd, pos, HIN_W'($urandom));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(5'd16, 150, 1'b0);
        run_random_phase(5'd31, 60, 1'b1);
        run_random_phase(5'd5, 80, 1'b0);
        run_random_phase(5'd0, 30, 1'b0);
        run_random_phase(5'd1, 40, 1'b0);
        run_random_phase(5'd9, 80, 1'b0);
        run_random_phase(5'd16, 60, 1'b1);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_capacity_limits();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
